[design/tsw_pkg.sv]
// Shared types, constants and helpers of the wrapped bilinear texture sampler.
package tsw_pkg;

  localparam int MaxSide  = 256;
  localparam int SideW    = $clog2(MaxSide) + 1;
  localparam int CoordW   = $clog2(MaxSide);
  localparam int FracBits = 16;
  localparam int AddrW    = 2 * CoordW;
  localparam int Depth    = MaxSide * MaxSide;
  localparam int RgbW     = 24;
  localparam int ChanW    = 8;
  localparam int TxW      = FracBits + SideW;
  localparam int OneW     = FracBits + 1;
  localparam int WeightW  = 2 * FracBits + 1;
  localparam int ProdW    = WeightW + ChanW;
  localparam int Drop     = 2 * FracBits - ChanW;
  localparam int ColorW   = 16;
  localparam int NumTaps  = 4;
  localparam int NumChan  = 3;

  localparam logic [ColorW-1:0] AlphaOne = 16'hFF00;
  localparam logic [OneW-1:0]   OneFrac  = OneW'(1) << FracBits;
  localparam logic [ProdW-1:0]  RoundHalf = ProdW'(1) << (Drop - 1);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    FILT_NEAREST = 2'd0,
    FILT_LINEAR  = 2'd1
  } filter_mode_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               kind;
    logic [15:0]        texel_index;
    logic [23:0]        texel_rgb;
    logic signed [23:0] u_coord;
    logic signed [23:0] v_coord;
    logic [1:0]         filter_mode;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_item_t;

  // Stage 1: captured transaction, fraction only
  typedef struct packed {
    logic                kind;
    logic [1:0]          mode;
    logic [AddrW-1:0]    idx;
    logic [RgbW-1:0]     rgb;
    logic [FracBits-1:0] fu;
    logic [FracBits-1:0] fv;
  } s1_t;

  // Stage 3: store addresses and blend weights
  typedef struct packed {
    logic                                   kind;
    logic [1:0]                             mode;
    logic [RgbW-1:0]                        rgb;
    logic [NumTaps-1:0][AddrW-1:0]          addr;
    logic [NumTaps-1:0][WeightW-1:0]        wgt;
  } s3_t;

  // Clamp a size register to 1..MaxSide
  function automatic logic [SideW-1:0] side_of(input logic [SideW-1:0] reg_val);
    logic [SideW-1:0] r;
    if (reg_val == '0) r = SideW'(1);
    else if (reg_val > SideW'(MaxSide)) r = SideW'(MaxSide);
    else r = reg_val;
    return r;
  endfunction

  // Row-major address y * w + x; always fits the store for in-range x, y
  function automatic logic [AddrW-1:0] texel_addr(input logic [CoordW-1:0] y,
                                                  input logic [CoordW-1:0] x,
                                                  input logic [SideW-1:0]  w);
    logic [CoordW+SideW-1:0] p;
    p = (CoordW+SideW)'(y) * (CoordW+SideW)'(w) + (CoordW+SideW)'(x);
    return p[AddrW-1:0];
  endfunction

endpackage

[design/texture_sampler_wrap_bilinear_core.sv]
// Top level of the wrapped nearest/bilinear texture sampler.
// The sampler takes one transaction per clock while the skid stage is empty, texel
// writes and sample requests alike, and presents one RGBA result per sample on the
// output in order, after stages s1 to s5 and the output register; writes return
// nothing. The rate comes from four copies of the 65536-texel store, each with its own
// read port, so all four bilinear taps are fetched in the same cycle; every write
// updates all copies. A write is visible to any sample accepted after it. The store
// is not cleared at reset: sample only texels that have been written. Image width and
// height may be changed only while no transaction is in flight. An output register plus
// a skid stage let the input keep accepting while one result waits to be taken.
module texture_sampler_wrap_bilinear_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tsw_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tsw_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [tsw_pkg::SideW-1:0]   cfg_wdata_i
);

  logic [tsw_pkg::SideW-1:0] width_q, height_q, width_side, height_side;
  logic                      en;
  logic                      s1_valid_q;
  tsw_pkg::s1_t              s1_d, s1_q;
  logic                      s3_valid;
  tsw_pkg::s3_t              s3;
  logic [tsw_pkg::NumTaps-1:0][tsw_pkg::RgbW-1:0] texel;
  logic                      res_valid;
  tsw_pkg::out_item_t        res;
  logic                      out_v_q, out_v_d, skid_v_q, skid_v_d;
  tsw_pkg::out_item_t        out_q, out_d, skid_q, skid_d;
  logic                      out_free, ram_we;

  // stall the whole pipeline only while the skid stage holds a result
  assign en          = !skid_v_q;
  assign in_ready_o  = en;
  assign width_side  = tsw_pkg::side_of(width_q);
  assign height_side = tsw_pkg::side_of(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tsw_pkg::SideW'(tsw_pkg::MaxSide);
      height_q <= tsw_pkg::SideW'(tsw_pkg::MaxSide);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsw_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        tsw_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_d.kind = in_item_i.kind;
    s1_d.mode = in_item_i.filter_mode;
    s1_d.idx  = in_item_i.texel_index;
    s1_d.rgb  = in_item_i.texel_rgb;
    // keep only the fraction: wrap
    s1_d.fu   = in_item_i.u_coord[tsw_pkg::FracBits-1:0];
    s1_d.fv   = in_item_i.v_coord[tsw_pkg::FracBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  tsw_coord u_coord (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .s1_valid_i (s1_valid_q),
    .s1_i       (s1_q),
    .width_i    (width_side),
    .height_i   (height_side),
    .s3_valid_o (s3_valid),
    .s3_o       (s3)
  );

  assign ram_we = en && s3_valid && (s3.kind == tsw_pkg::KIND_WRITE);

  for (genvar k = 0; k < tsw_pkg::NumTaps; k++) begin : g_store
    tsw_ram #(
      .Width (tsw_pkg::RgbW),
      .Depth (tsw_pkg::Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (s3.addr[0]),
      .wdata_i (s3.rgb),
      .re_i    (en),
      .raddr_i (s3.addr[k]),
      .rdata_o (texel[k])
    );
  end

  tsw_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .s3_valid_i  (s3_valid),
    .s3_i        (s3),
    .texel_i     (texel),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_free) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_v_d = 1'b1;
        out_d   = res;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid stage filled while output register was free");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a result ahead of the output register");

  a_alpha_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.alpha_out == tsw_pkg::AlphaOne))
    else $error("alpha of a result is not one");

endmodule

[design/tsw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsw_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tsw_coord.sv]
// Coordinate stages: texel-space scaling, then tap addresses and bilinear weights.
module tsw_coord (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         s1_valid_i,
  input  tsw_pkg::s1_t                 s1_i,
  input  logic [tsw_pkg::SideW-1:0]    width_i,
  input  logic [tsw_pkg::SideW-1:0]    height_i,
  output logic                         s3_valid_o,
  output tsw_pkg::s3_t                 s3_o
);

  typedef struct packed {
    logic                         kind;
    logic [1:0]                   mode;
    logic [tsw_pkg::AddrW-1:0]    idx;
    logic [tsw_pkg::RgbW-1:0]     rgb;
    logic [tsw_pkg::TxW-1:0]      tx;
    logic [tsw_pkg::TxW-1:0]      ty;
  } s2_t;

  logic s2_valid_q, s3_valid_q;
  s2_t  s2_d, s2_q;
  tsw_pkg::s3_t s3_d, s3_q;

  logic [tsw_pkg::CoordW-1:0]   x0, y0, x1, y1;
  logic [tsw_pkg::SideW-1:0]    x0p, y0p, wm1, hm1;
  logic [tsw_pkg::FracBits-1:0] fx, fy;
  logic [tsw_pkg::OneW-1:0]     ofx, ofy;
  logic [2*tsw_pkg::OneW-1:0]   w00, w10, w01, w11;

  always_comb begin
    s2_d.kind = s1_i.kind;
    s2_d.mode = s1_i.mode;
    s2_d.idx  = s1_i.idx;
    s2_d.rgb  = s1_i.rgb;
    s2_d.tx   = tsw_pkg::TxW'(s1_i.fu) * tsw_pkg::TxW'(width_i);
    s2_d.ty   = tsw_pkg::TxW'(s1_i.fv) * tsw_pkg::TxW'(height_i);
  end

  always_comb begin
    x0  = s2_q.tx[tsw_pkg::FracBits +: tsw_pkg::CoordW];
    y0  = s2_q.ty[tsw_pkg::FracBits +: tsw_pkg::CoordW];
    fx  = s2_q.tx[tsw_pkg::FracBits-1:0];
    fy  = s2_q.ty[tsw_pkg::FracBits-1:0];
    x0p = tsw_pkg::SideW'(x0) + tsw_pkg::SideW'(1);
    y0p = tsw_pkg::SideW'(y0) + tsw_pkg::SideW'(1);
    wm1 = width_i - tsw_pkg::SideW'(1);
    hm1 = height_i - tsw_pkg::SideW'(1);
    // clamp the +1 neighbours to the last column and row
    x1  = (x0p < width_i)  ? x0p[tsw_pkg::CoordW-1:0] : wm1[tsw_pkg::CoordW-1:0];
    y1  = (y0p < height_i) ? y0p[tsw_pkg::CoordW-1:0] : hm1[tsw_pkg::CoordW-1:0];
    ofx = tsw_pkg::OneFrac - tsw_pkg::OneW'(fx);
    ofy = tsw_pkg::OneFrac - tsw_pkg::OneW'(fy);
    w00 = (2*tsw_pkg::OneW)'(ofx) * (2*tsw_pkg::OneW)'(ofy);
    w10 = (2*tsw_pkg::OneW)'(fx) * (2*tsw_pkg::OneW)'(ofy);
    w01 = (2*tsw_pkg::OneW)'(ofx) * (2*tsw_pkg::OneW)'(fy);
    w11 = (2*tsw_pkg::OneW)'(fx) * (2*tsw_pkg::OneW)'(fy);

    s3_d.kind   = s2_q.kind;
    s3_d.mode   = s2_q.mode;
    s3_d.rgb    = s2_q.rgb;
    s3_d.wgt[0] = w00[tsw_pkg::WeightW-1:0];
    s3_d.wgt[1] = w10[tsw_pkg::WeightW-1:0];
    s3_d.wgt[2] = w01[tsw_pkg::WeightW-1:0];
    s3_d.wgt[3] = w11[tsw_pkg::WeightW-1:0];
    if (s2_q.kind == tsw_pkg::KIND_WRITE) begin
      s3_d.addr = {tsw_pkg::NumTaps{s2_q.idx}};
    end else begin
      s3_d.addr[0] = tsw_pkg::texel_addr(y0, x0, width_i);
      s3_d.addr[1] = tsw_pkg::texel_addr(y0, x1, width_i);
      s3_d.addr[2] = tsw_pkg::texel_addr(y1, x0, width_i);
      s3_d.addr[3] = tsw_pkg::texel_addr(y1, x1, width_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign s3_valid_o = s3_valid_q;
  assign s3_o       = s3_q;

endmodule

[design/tsw_blend.sv]
// Blend stages: per-channel weighted products, then sum, round and mode select.
module tsw_blend (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             s3_valid_i,
  input  tsw_pkg::s3_t                                     s3_i,
  input  logic [tsw_pkg::NumTaps-1:0][tsw_pkg::RgbW-1:0]   texel_i,
  output logic                                             res_valid_o,
  output tsw_pkg::out_item_t                               res_o
);

  typedef logic [tsw_pkg::NumTaps-1:0][tsw_pkg::WeightW-1:0] wgt_t;
  typedef logic [tsw_pkg::NumChan-1:0][tsw_pkg::NumTaps-1:0][tsw_pkg::ProdW-1:0] prod_t;

  logic                       s4_valid_q, s5_valid_q;
  logic [1:0]                 s4_mode_q, s5_mode_q;
  wgt_t                       s4_wgt_q;
  prod_t                      prod_d, prod_q;
  logic [tsw_pkg::RgbW-1:0]   near_q;
  logic [tsw_pkg::NumChan-1:0][tsw_pkg::ColorW-1:0] color;
  logic [tsw_pkg::ProdW-1:0]  sum;
  logic [tsw_pkg::ChanW-1:0]  ch;

  always_comb begin
    for (int c = 0; c < tsw_pkg::NumChan; c++) begin
      for (int k = 0; k < tsw_pkg::NumTaps; k++) begin
        ch = texel_i[k][(tsw_pkg::NumChan-1-c)*tsw_pkg::ChanW +: tsw_pkg::ChanW];
        prod_d[c][k] = tsw_pkg::ProdW'(ch) * tsw_pkg::ProdW'(s4_wgt_q[k]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < tsw_pkg::NumChan; c++) begin
      sum = prod_q[c][0] + prod_q[c][1] + prod_q[c][2] + prod_q[c][3] + tsw_pkg::RoundHalf;
      unique case (s5_mode_q)
        tsw_pkg::FILT_NEAREST: color[c] =
          {near_q[(tsw_pkg::NumChan-1-c)*tsw_pkg::ChanW +: tsw_pkg::ChanW], 8'h00};
        tsw_pkg::FILT_LINEAR:  color[c] = sum[tsw_pkg::Drop +: tsw_pkg::ColorW];
        default:               color[c] = '0;
      endcase
    end
    res_o.red_out   = color[0];
    res_o.green_out = color[1];
    res_o.blue_out  = color[2];
    res_o.alpha_out = tsw_pkg::AlphaOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      // drop texel writes, they give no result
      s4_valid_q <= s3_valid_i && (s3_i.kind == tsw_pkg::KIND_SAMPLE);
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_mode_q <= s3_i.mode;
      s4_wgt_q  <= s3_i.wgt;
      s5_mode_q <= s4_mode_q;
      prod_q    <= prod_d;
      near_q    <= texel_i[0];
    end
  end

  assign res_valid_o = s5_valid_q;

endmodule
